>>> rtl/ifr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifr_pkg
// Types and constants shared by the frame receiver and destuffer modules.
// ----------------------------------------------------------------------------
package ifr_pkg;

   localparam logic [7:0] FLAG_BYTE  = 8'h7E;
   localparam logic [7:0] ESC_BYTE   = 8'h7D;
   localparam logic [7:0] STUFF_MASK = 8'h20;
   localparam logic [7:0] CTRL_I0    = 8'h00;
   localparam logic [7:0] CTRL_I1    = 8'h80;
   localparam logic [7:0] CTRL_RR0   = 8'hAA;
   localparam logic [7:0] CTRL_RR1   = 8'hAB;
   localparam logic [7:0] CTRL_REJ0  = 8'h54;
   localparam logic [7:0] CTRL_REJ1  = 8'h55;
   localparam logic [7:0] CTRL_DISC  = 8'h0B;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   localparam logic [2:0] BEAT_OPEN  = 3'd0;
   localparam logic [2:0] BEAT_ADDR  = 3'd1;
   localparam logic [2:0] BEAT_CTRL  = 3'd2;
   localparam logic [2:0] BEAT_CHECK = 3'd3;
   localparam logic [2:0] BEAT_CLOSE = 3'd4;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_REPLY   = 2'd1,
      KIND_DISC    = 2'd2
   } kind_type;

   typedef enum logic [4:0] {
      ST_START = 5'b00001,
      ST_FLAG  = 5'b00010,
      ST_ADDR  = 5'b00100,
      ST_CTRL  = 5'b01000,
      ST_DATA  = 5'b10000
   } hunt_type;

   // one queued command: a payload byte, a disconnect, or a whole reply run
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic        ok;
      logic [15:0] length;
   } cmd_type;

endpackage

>>> rtl/info_frame_receiver_destuffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// info_frame_receiver_destuffer
// Receiver for flag-framed, byte-stuffed information frames with RR/REJ
// reply generation and disconnect indication.
// ----------------------------------------------------------------------------
// One line byte is accepted per clock while req_full is low. The parser
// handles each byte in the cycle it is accepted and queues at most one
// command into a CMD_DEPTH-entry queue; the result side turns a payload or
// disconnect command into one transfer and a closing flag into a
// five-transfer reply run, one transfer per cycle from its output register
// while rsp_pop takes it. A result passes through the command queue and
// then the output register before it reaches the rsp_ ports; a payload byte
// is caused by the line byte that follows it. req_full rises only when the
// command queue is full, which a reply run or a stalled consumer can cause;
// with a free-running consumer and no replies the sustained rate is one byte
// per cycle. Write the address register only while nothing is in flight.
// ----------------------------------------------------------------------------
module info_frame_receiver_destuffer
   import ifr_pkg::*;
#(
   parameter int CMD_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data,
   output logic        rsp_last,
   output logic        rsp_frame_ok,
   output logic [15:0] rsp_frame_length,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   logic [7:0] address_ff;
   logic       fire;
   logic       cmd_valid;
   cmd_type    cmd;
   cmd_type    head_cmd;
   logic       head_pop;
   logic       fifo_empty;

   assign fire = req_push && !req_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff <= 8'h03;
      end else if (csr_write_enable) begin
         address_ff <= csr_write_data;
      end
   end

   ifr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .rx_byte   (req_rx_byte),
      .address   (address_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   ifr_cmd_fifo #(
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_valid),
      .push_cmd (cmd),
      .pop      (head_pop),
      .head_cmd (head_cmd),
      .full     (req_full),
      .empty    (fifo_empty)
   );

   ifr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .address          (address_ff),
      .head_valid       (!fifo_empty),
      .head_cmd         (head_cmd),
      .head_pop         (head_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_kind         (rsp_kind),
      .rsp_data         (rsp_data),
      .rsp_last         (rsp_last),
      .rsp_frame_ok     (rsp_frame_ok),
      .rsp_frame_length (rsp_frame_length)
   );

endmodule

>>> rtl/ifr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifr_front
// Frame hunter and destuffer: parses one line byte per transfer and queues
// at most one command for it.
// ----------------------------------------------------------------------------
module ifr_front
   import ifr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] rx_byte,
   input  logic [7:0] address,
   output logic       cmd_valid,
   output cmd_type    cmd
);

   hunt_type    state_ff, state_in;
   logic        control_bit_ff, control_bit_in;
   logic        escape_ff, escape_in;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic        held_valid_ff, held_valid_in;
   logic [7:0]  parity_ff, parity_in;
   logic [15:0] count_ff, count_in;
   logic        seq_ff, seq_in;

   logic [7:0]  ctrl_expect;
   logic        take;
   logic [7:0]  take_byte;
   logic        frame_ok;
   logic [7:0]  reply_ctrl;

   always_comb begin
      ctrl_expect = control_bit_ff ? CTRL_I1 : CTRL_I0;
      frame_ok    = held_valid_ff && (held_byte_ff == parity_ff);
      if (frame_ok) begin
         reply_ctrl = seq_ff ? CTRL_RR1 : CTRL_RR0;
      end else begin
         reply_ctrl = seq_ff ? CTRL_REJ1 : CTRL_REJ0;
      end
   end

   always_comb begin
      state_in       = state_ff;
      control_bit_in = control_bit_ff;
      escape_in      = escape_ff;
      held_byte_in   = held_byte_ff;
      held_valid_in  = held_valid_ff;
      parity_in      = parity_ff;
      count_in       = count_ff;
      seq_in         = seq_ff;
      take           = 1'b0;
      take_byte      = rx_byte;
      cmd_valid      = 1'b0;
      cmd.kind       = KIND_PAYLOAD;
      cmd.data       = held_byte_ff;
      cmd.ok         = 1'b0;
      cmd.length     = '0;

      if (fire) begin
         unique case (state_ff)
            ST_FLAG: begin
               if (rx_byte == address) begin
                  state_in = ST_ADDR;
               end else if (rx_byte != FLAG_BYTE) begin
                  state_in = ST_START;
               end
            end
            ST_ADDR: begin
               if (rx_byte == FLAG_BYTE) begin
                  state_in = ST_FLAG;
               end else if (rx_byte == CTRL_I0 || rx_byte == CTRL_I1) begin
                  control_bit_in = (rx_byte == CTRL_I1);
                  state_in       = ST_CTRL;
               end else if (rx_byte == CTRL_DISC) begin
                  cmd_valid = 1'b1;
                  cmd.kind  = KIND_DISC;
                  cmd.data  = CTRL_DISC;
                  state_in  = ST_START;
               end else begin
                  state_in = ST_START;
               end
            end
            ST_CTRL: begin
               if (rx_byte == (address ^ ctrl_expect)) begin
                  state_in      = ST_DATA;
                  escape_in     = 1'b0;
                  held_byte_in  = '0;
                  held_valid_in = 1'b0;
                  parity_in     = '0;
                  count_in      = '0;
               end else if (rx_byte == FLAG_BYTE) begin
                  state_in = ST_FLAG;
               end else begin
                  state_in = ST_START;
               end
            end
            ST_DATA: begin
               if (escape_ff) begin
                  escape_in = 1'b0;
                  take      = 1'b1;
                  take_byte = rx_byte ^ STUFF_MASK;
               end else if (rx_byte == ESC_BYTE) begin
                  escape_in = 1'b1;
               end else if (rx_byte == FLAG_BYTE) begin
                  cmd_valid  = 1'b1;
                  cmd.kind   = KIND_REPLY;
                  cmd.data   = reply_ctrl;
                  cmd.ok     = frame_ok;
                  cmd.length = count_ff;
                  seq_in     = seq_ff ^ frame_ok;
                  state_in   = ST_START;
               end else begin
                  take = 1'b1;
               end
            end
            default: begin
               state_in = (rx_byte == FLAG_BYTE) ? ST_FLAG : ST_START;
            end
         endcase
      end

      // release the held byte, keep the new one back
      if (take) begin
         if (held_valid_ff) begin
            cmd_valid = 1'b1;
            parity_in = parity_ff ^ held_byte_ff;
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + 16'd1;
            end
         end
         held_byte_in  = take_byte;
         held_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_START;
         control_bit_ff <= 1'b0;
         escape_ff      <= 1'b0;
         held_byte_ff   <= '0;
         held_valid_ff  <= 1'b0;
         parity_ff      <= '0;
         count_ff       <= '0;
         seq_ff         <= 1'b0;
      end else begin
         state_ff       <= state_in;
         control_bit_ff <= control_bit_in;
         escape_ff      <= escape_in;
         held_byte_ff   <= held_byte_in;
         held_valid_ff  <= held_valid_in;
         parity_ff      <= parity_in;
         count_ff       <= count_in;
         seq_ff         <= seq_in;
      end
   end

`ifndef SYNTHESIS
   a_reply_returns_to_start: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && cmd.kind == KIND_REPLY) |=> (state_ff == ST_START))
      else $error("reply issued without returning to hunting");
`endif

endmodule

>>> rtl/ifr_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifr_cmd_fifo
// Short command queue between the frame parser and the result generator.
// ----------------------------------------------------------------------------
module ifr_cmd_fifo
   import ifr_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    full,
   output logic    empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
   localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

   cmd_type         slot_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full     = (count_ff == COUNT_FULL);
   assign empty    = (count_ff == '0);
   assign head_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("command queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("command queue underflow");
`endif

endmodule

>>> rtl/ifr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifr_back
// Result generator: expands queued commands into result transfers and
// holds the current one in the output register.
// ----------------------------------------------------------------------------
module ifr_back
   import ifr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  address,
   input  logic        head_valid,
   input  cmd_type     head_cmd,
   output logic        head_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data,
   output logic        rsp_last,
   output logic        rsp_frame_ok,
   output logic [15:0] rsp_frame_length
);

   cmd_type    cur_ff, cur_in;
   logic       busy_ff, busy_in;
   logic [2:0] beat_ff, beat_in;
   logic       is_reply;
   logic       final_beat;
   logic       taken;

   assign is_reply   = (cur_ff.kind == KIND_REPLY);
   assign final_beat = !is_reply || (beat_ff == BEAT_CLOSE);
   assign taken      = busy_ff && rsp_pop;
   assign head_pop   = head_valid && (!busy_ff || (taken && final_beat));

   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      beat_in = beat_ff;
      if (head_pop) begin
         cur_in  = head_cmd;
         busy_in = 1'b1;
         beat_in = BEAT_OPEN;
      end else if (taken) begin
         if (final_beat) begin
            busy_in = 1'b0;
         end else begin
            beat_in = beat_ff + 3'd1;
         end
      end
   end

   always_comb begin
      rsp_empty        = !busy_ff;
      rsp_kind         = cur_ff.kind;
      rsp_last         = is_reply && (beat_ff == BEAT_CLOSE);
      rsp_frame_ok     = cur_ff.ok;
      rsp_frame_length = cur_ff.length;
      rsp_data         = cur_ff.data;
      if (is_reply) begin
         case (beat_ff)
            BEAT_OPEN:  rsp_data = FLAG_BYTE;
            BEAT_ADDR:  rsp_data = address;
            BEAT_CTRL:  rsp_data = cur_ff.data;
            BEAT_CHECK: rsp_data = address ^ cur_ff.data;
            default:    rsp_data = FLAG_BYTE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         beat_ff <= BEAT_OPEN;
      end else begin
         busy_ff <= busy_in;
         beat_ff <= beat_in;
      end
   end

`ifndef SYNTHESIS
   a_beat_advances: assert property (@(posedge clock) disable iff (reset)
      (taken && is_reply && beat_ff != BEAT_CLOSE)
      |=> (busy_ff && beat_ff == $past(beat_ff) + 3'd1))
      else $error("reply run did not advance");
   a_beat_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (beat_ff <= BEAT_CLOSE && (is_reply || beat_ff == BEAT_OPEN)))
      else $error("reply beat out of range");
`endif

endmodule
